>>> src/mqttrx_pkg.sv
`default_nettype none
package mqttrx_pkg;

    localparam int PENDING_SLOTS_DEF = 16;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_BODY    = 3'd2;
    localparam logic [2:0] PH_TOPIC   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;

    localparam logic [3:0] EV_TOPIC        = 4'd0;
    localparam logic [3:0] EV_PAYLOAD      = 4'd1;
    localparam logic [3:0] EV_ACCEPTED     = 4'd2;
    localparam logic [3:0] EV_REFUSED      = 4'd3;
    localparam logic [3:0] EV_SUBSCRIBED   = 4'd4;
    localparam logic [3:0] EV_UNSUBSCRIBED = 4'd5;
    localparam logic [3:0] EV_PINGRESP     = 4'd6;
    localparam logic [3:0] EV_MALFORMED    = 4'd7;
    localparam logic [3:0] EV_UNEXPECTED   = 4'd8;
    localparam logic [3:0] EV_UNSUPPORTED  = 4'd9;
    localparam logic [3:0] EV_BAD_LENGTH   = 4'd10;
    localparam logic [3:0] EV_ISSUED       = 4'd11;
    localparam logic [3:0] EV_FULL         = 4'd12;

    localparam logic [3:0] KIND_CONNACK  = 4'd2;
    localparam logic [3:0] KIND_PUBLISH  = 4'd3;
    localparam logic [3:0] KIND_SUBACK   = 4'd9;
    localparam logic [3:0] KIND_UNSUBACK = 4'd11;
    localparam logic [3:0] KIND_PINGRESP = 4'd13;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_SUB   = 2'd1;
    localparam logic [1:0] ACT_UNSUB = 2'd2;

    // Operation broadcast to every table cell.
    typedef struct packed {
        logic        store_en;
        logic        take_en;
        logic        kind;
        logic [15:0] id;
    } cell_op_t;

endpackage
`default_nettype wire

>>> src/mqttrx_cell.sv
`default_nettype none
module mqttrx_cell
    import mqttrx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cell_op_t op,
    input  wire logic     free_in,
    output logic          free_out,
    output logic          match
);

    logic        valid_reg;
    logic        kind_reg;
    logic [15:0] id_reg;
    logic        claim;

    assign match    = valid_reg && (kind_reg == op.kind) && (id_reg == op.id);
    // The first empty cell along the chain takes a new entry.
    assign claim    = !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op.take_en && match)
        begin
            valid_reg <= 1'b0;
        end
        else if (op.store_en && claim)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.store_en && claim)
        begin
            kind_reg <= op.kind;
            id_reg   <= op.id;
        end
    end

endmodule
`default_nettype wire

>>> src/mqtt_client_rx_packet_parser.sv
// An accepted transaction's result is registered in the output register.
// One transaction per cycle while m_tready does not stall the output, bytes and identifier requests alike.
// The pending table is a chain of cells compared in parallel, so its depth does not
// change the rate. Reset is asynchronous and active low; it empties the table, sets
// the next identifier to one and returns the parser to the header byte.
`default_nettype none
module mqtt_client_rx_packet_parser
    import mqttrx_pkg::*;
#(
    parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] data_byte, [15:8] return_code, [31:16] packet_id
    output logic [3:0]       m_tuser,   // [3:0] event_res
    output logic             m_tlast    // packet_end
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [27:0] left_reg, left_next;
    logic        pos_reg, pos_next;
    logic [15:0] topic_reg, topic_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] next_id_reg, next_id_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [3:0]  out_ev_reg, out_ev_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    logic        res_valid;
    logic [3:0]  ev;
    logic [7:0]  dbyte;
    logic        pend;
    logic [7:0]  rc;
    logic [15:0] pid;
    logic [27:0] left_or;
    logic [27:0] left_dec;
    logic [15:0] word;
    logic [15:0] id_inc;
    logic [1:0]  need;
    logic        issue_en;
    logic        take_en;
    logic        any_match;
    cell_op_t    op;

    logic [PENDING_SLOTS-1:0] match_vec;
    logic [PENDING_SLOTS:0]   free_chain;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    assign op.kind     = issue_en ? s_tuser[1] : (kind_reg == KIND_UNSUBACK);
    assign op.id       = issue_en ? next_id_reg : word;
    assign op.take_en  = take_en;
    assign op.store_en = issue_en && !any_match;
    assign any_match   = |match_vec;
    assign free_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < PENDING_SLOTS; g++)
        begin : g_cell
            mqttrx_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (op),
                .free_in  (free_chain[g]),
                .free_out (free_chain[g+1]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    assign left_dec = left_reg - 28'd1;
    assign word     = {held_reg, s_tdata};
    assign id_inc   = (next_id_reg == 16'hFFFF) ? 16'd1 : next_id_reg + 16'd1;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    left_or = left_reg | {21'd0, s_tdata[6:0]};
            2'd1:    left_or = left_reg | {14'd0, s_tdata[6:0], 7'd0};
            2'd2:    left_or = left_reg | {7'd0, s_tdata[6:0], 14'd0};
            default: left_or = left_reg | {s_tdata[6:0], 21'd0};
        endcase
        case (kind_reg)
            KIND_CONNACK, KIND_UNSUBACK, KIND_PUBLISH: need = 2'd2;
            KIND_SUBACK:                               need = 2'd3;
            default:                                   need = 2'd0;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        topic_next   = topic_reg;
        held_next    = held_reg;
        next_id_next = next_id_reg;
        res_valid    = 1'b0;
        ev           = EV_TOPIC;
        dbyte        = 8'd0;
        pend         = 1'b0;
        rc           = 8'd0;
        pid          = 16'd0;
        issue_en     = 1'b0;
        take_en      = 1'b0;

        if (accept && (s_tuser == ACT_SUB || s_tuser == ACT_UNSUB))
        begin
            issue_en  = 1'b1;
            res_valid = 1'b1;
            if (any_match || free_chain[PENDING_SLOTS])
            begin
                ev           = EV_ISSUED;
                pid          = next_id_reg;
                next_id_next = id_inc;
            end
            else
            begin
                ev = EV_FULL;
            end
        end
        else if (accept && s_tuser == ACT_BYTE)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if (s_tdata[7])
                    begin
                        if (cnt_reg == 2'd3)
                        begin
                            phase_next = PH_HEADER;
                            cnt_next   = 2'd0;
                            left_next  = 28'd0;
                            res_valid  = 1'b1;
                            ev         = EV_BAD_LENGTH;
                            pend       = 1'b1;
                        end
                        else
                        begin
                            cnt_next  = cnt_reg + 2'd1;
                            left_next = left_or;
                        end
                    end
                    else
                    begin
                        left_next = left_or;
                        if (need != 2'd0 && left_or >= {26'd0, need})
                        begin
                            phase_next = PH_BODY;
                            pos_next   = 1'b0;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            if (need != 2'd0)
                                ev = EV_MALFORMED;
                            else if (kind_reg == KIND_PINGRESP)
                                ev = EV_PINGRESP;
                            else
                                ev = EV_UNSUPPORTED;
                            pend       = (left_or == 28'd0);
                            phase_next = pend ? PH_HEADER : PH_SKIP;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (left_reg == 28'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_dec;
                        pend      = (left_dec == 28'd0);
                        if (!pos_reg)
                        begin
                            held_next = s_tdata;
                            pos_next  = 1'b1;
                            if (pend)
                                phase_next = PH_HEADER;
                            pend = 1'b0;
                        end
                        else if (kind_reg == KIND_PUBLISH)
                        begin
                            if (word == 16'd0 || {12'd0, word} > left_dec)
                            begin
                                res_valid  = 1'b1;
                                ev         = EV_MALFORMED;
                                phase_next = pend ? PH_HEADER : PH_SKIP;
                            end
                            else
                            begin
                                topic_next = word;
                                phase_next = PH_TOPIC;
                                pend       = 1'b0;
                            end
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            phase_next = pend ? PH_HEADER : PH_SKIP;
                            if (kind_reg == KIND_CONNACK)
                            begin
                                ev = (s_tdata == 8'd0) ? EV_ACCEPTED : EV_REFUSED;
                                rc = s_tdata;
                            end
                            else
                            begin
                                take_en = 1'b1;
                                pid     = word;
                                if (!any_match)
                                    ev = EV_UNEXPECTED;
                                else if (kind_reg == KIND_SUBACK)
                                    ev = EV_SUBSCRIBED;
                                else
                                    ev = EV_UNSUBSCRIBED;
                            end
                        end
                    end
                end
                PH_TOPIC:
                begin
                    if (left_reg == 28'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_dec;
                        if (topic_reg != 16'd0)
                            topic_next = topic_reg - 16'd1;
                        pend      = (left_dec == 28'd0);
                        res_valid = 1'b1;
                        ev        = EV_TOPIC;
                        dbyte     = s_tdata;
                        if (pend)
                            phase_next = PH_HEADER;
                        else if (topic_reg <= 16'd1)
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (left_reg == 28'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_dec;
                        pend      = (left_dec == 28'd0);
                        res_valid = 1'b1;
                        ev        = EV_PAYLOAD;
                        dbyte     = s_tdata;
                        if (pend)
                            phase_next = PH_HEADER;
                    end
                end
                PH_SKIP:
                begin
                    if (left_reg <= 28'd1)
                    begin
                        left_next  = 28'd0;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        left_next = left_dec;
                    end
                end
                default:
                begin
                    kind_next  = s_tdata[7:4];
                    cnt_next   = 2'd0;
                    left_next  = 28'd0;
                    pos_next   = 1'b0;
                    phase_next = PH_LENGTH;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;
        if (accept)
        begin
            out_valid_next = res_valid;
            out_data_next  = {pid, rc, dbyte};
            out_ev_next    = ev;
            out_last_next  = pend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            kind_reg      <= 4'd0;
            cnt_reg       <= 2'd0;
            left_reg      <= 28'd0;
            pos_reg       <= 1'b0;
            topic_reg     <= 16'd0;
            held_reg      <= 8'd0;
            next_id_reg   <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            topic_reg     <= topic_next;
            held_reg      <= held_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ev_reg   <= out_ev_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 16'd0)
        else $error("next identifier is zero");

    a_issued_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == EV_ISSUED) |-> (!m_tlast && m_tdata[31:16] != 16'd0))
        else $error("issued identifier result is malformed");

    a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && issue_en && !any_match && !free_chain[PENDING_SLOTS])
        |=> (m_tvalid && m_tuser == EV_FULL && $stable(next_id_reg)))
        else $error("table full handling is wrong");
`endif

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
module testbench;
    import mqttrx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  ev;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  rc;
        logic [15:0] id;
    } mqtt_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    mqtt_client_rx_packet_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Parser state mirrored from the block.
    logic [2:0]  phase;
    logic [3:0]  kind;
    logic [1:0]  len_count;
    logic [27:0] remaining;
    logic [1:0]  body_pos;
    logic [15:0] topic_left;
    logic [7:0]  held;
    logic [15:0] next_id;
    logic        pend_valid [SLOTS];
    logic        pend_kind  [SLOTS];
    logic [15:0] pend_id    [SLOTS];

    mqtt_event_t expected_events[$];
    int  mismatches;
    bit  failed;
    bit  idle_sender;
    bit  idle_receiver;
    bit  hold_receiver;
    int  idle_cycles;
    int  rx_gap;

    task automatic parser_reset_model();
        phase = PH_HEADER;
        kind = '0;
        len_count = '0;
        remaining = '0;
        body_pos = '0;
        topic_left = '0;
        held = '0;
        next_id = 16'd1;
        for (int i = 0; i < SLOTS; i++)
        begin
            pend_valid[i] = 1'b0;
            pend_kind[i] = 1'b0;
            pend_id[i] = '0;
        end
    endtask

    function automatic mqtt_event_t make_event(logic [3:0] ev, logic [7:0] d, logic e,
                                               logic [7:0] rc, logic [15:0] id);
        mqtt_event_t r;
        r.ev = ev;
        r.data = d;
        r.last = e;
        r.rc = rc;
        r.id = id;
        return r;
    endfunction

    task automatic bump_id();
        next_id = next_id + 16'd1;
        if (next_id == 16'd0)
            next_id = 16'd1;
    endtask

    task automatic issue_identifier(logic k);
        logic [15:0] id;
        id = next_id;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pend_valid[i] && pend_kind[i] == k && pend_id[i] == id)
            begin
                bump_id();
                expected_events.push_back(make_event(EV_ISSUED, 0, 0, 0, id));
                return;
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!pend_valid[i])
            begin
                pend_valid[i] = 1'b1;
                pend_kind[i] = k;
                pend_id[i] = id;
                bump_id();
                expected_events.push_back(make_event(EV_ISSUED, 0, 0, 0, id));
                return;
            end
        end
        expected_events.push_back(make_event(EV_FULL, 0, 0, 0, 0));
    endtask

    function automatic bit retire_identifier(logic k, logic [15:0] id);
        bit hit;
        hit = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pend_valid[i] && pend_kind[i] == k && pend_id[i] == id)
            begin
                pend_valid[i] = 1'b0;
                hit = 1;
            end
        end
        return hit;
    endfunction

    // Advances the mirrored parser by one transaction and queues any event it causes.
    task automatic predict_event(logic [1:0] act, logic [7:0] b);
        int unsigned need;
        logic        e;
        logic [15:0] word;
        logic [3:0]  ev;
        if (act == ACT_SUB || act == ACT_UNSUB)
        begin
            issue_identifier(act == ACT_UNSUB);
            return;
        end
        if (act != ACT_BYTE)
            return;
        case (phase)
            PH_LENGTH:
            begin
                remaining = remaining | (28'(b[6:0]) << (7 * len_count));
                if (b[7])
                begin
                    if (len_count == 2'd3)
                    begin
                        phase = PH_HEADER;
                        len_count = 0;
                        remaining = 0;
                        expected_events.push_back(make_event(EV_BAD_LENGTH, 0, 1, 0, 0));
                        return;
                    end
                    len_count++;
                    return;
                end
                need = 0;
                if (kind == KIND_CONNACK || kind == KIND_UNSUBACK || kind == KIND_PUBLISH)
                    need = 2;
                else if (kind == KIND_SUBACK)
                    need = 3;
                if (need != 0)
                begin
                    if (remaining >= need)
                    begin
                        phase = PH_BODY;
                        body_pos = 0;
                        return;
                    end
                    ev = EV_MALFORMED;
                end
                else
                    ev = (kind == KIND_PINGRESP) ? EV_PINGRESP : EV_UNSUPPORTED;
                e = (remaining == 0);
                phase = e ? PH_HEADER : PH_SKIP;
                expected_events.push_back(make_event(ev, 0, e, 0, 0));
            end
            PH_BODY:
            begin
                if (remaining == 0)
                begin
                    phase = PH_HEADER;
                    return;
                end
                remaining--;
                if (body_pos == 0)
                begin
                    held = b;
                    body_pos = 1;
                    if (remaining == 0)
                        phase = PH_HEADER;
                    return;
                end
                e = (remaining == 0);
                word = {held, b};
                if (kind == KIND_PUBLISH)
                begin
                    if (word == 0 || 28'(word) > remaining)
                    begin
                        phase = e ? PH_HEADER : PH_SKIP;
                        expected_events.push_back(make_event(EV_MALFORMED, 0, e, 0, 0));
                        return;
                    end
                    topic_left = word;
                    phase = PH_TOPIC;
                    return;
                end
                phase = e ? PH_HEADER : PH_SKIP;
                if (kind == KIND_CONNACK)
                    expected_events.push_back(make_event(b == 0 ? EV_ACCEPTED : EV_REFUSED,
                                                         0, e, b, 0));
                else if (kind == KIND_SUBACK)
                    expected_events.push_back(make_event(retire_identifier(0, word) ?
                                              EV_SUBSCRIBED : EV_UNEXPECTED, 0, e, 0, word));
                else
                    expected_events.push_back(make_event(retire_identifier(1, word) ?
                                              EV_UNSUBSCRIBED : EV_UNEXPECTED, 0, e, 0, word));
            end
            PH_TOPIC:
            begin
                if (remaining == 0)
                begin
                    phase = PH_HEADER;
                    return;
                end
                remaining--;
                if (topic_left != 0)
                    topic_left--;
                e = (remaining == 0);
                if (e)
                    phase = PH_HEADER;
                else if (topic_left == 0)
                    phase = PH_PAYLOAD;
                expected_events.push_back(make_event(EV_TOPIC, b, e, 0, 0));
            end
            PH_PAYLOAD:
            begin
                if (remaining == 0)
                begin
                    phase = PH_HEADER;
                    return;
                end
                remaining--;
                e = (remaining == 0);
                if (e)
                    phase = PH_HEADER;
                expected_events.push_back(make_event(EV_PAYLOAD, b, e, 0, 0));
            end
            PH_SKIP:
            begin
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                    phase = PH_HEADER;
            end
            default:
            begin
                kind = b[7:4];
                len_count = 0;
                remaining = 0;
                body_pos = 0;
                phase = PH_LENGTH;
            end
        endcase
    endtask

    // Sends one transaction, holding it until the block takes it.
    task automatic send_item(logic [1:0] act, logic [7:0] b);
        int gap;
        bit ready_seen;
        if (idle_sender && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= b;
        // Ready is sampled in the second half of the cycle, where it is settled.
        forever
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
            if (ready_seen)
                break;
        end
        predict_event(act, b);
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_item(ACT_BYTE, bytes[i]);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Remaining length encoding, shortest form.
    task automatic send_length(int unsigned len);
        do
        begin
            if (len > 127)
                send_item(ACT_BYTE, 8'(len[6:0]) | 8'h80);
            else
                send_item(ACT_BYTE, 8'(len[6:0]));
            len = len >> 7;
        end
        while (len != 0);
    endtask

    task automatic send_publish(int unsigned topic_len, int unsigned payload_len);
        int unsigned total;
        total = 2 + topic_len + payload_len;
        send_item(ACT_BYTE, {KIND_PUBLISH, 4'($urandom)});
        send_length(total);
        send_item(ACT_BYTE, 8'(topic_len >> 8));
        send_item(ACT_BYTE, 8'(topic_len));
        repeat (topic_len + payload_len)
            send_item(ACT_BYTE, 8'($urandom));
    endtask

    task automatic send_ack(logic [3:0] k, logic [15:0] id, int unsigned extra);
        send_item(ACT_BYTE, {k, 4'($urandom)});
        send_length(2 + extra);
        send_item(ACT_BYTE, id[15:8]);
        send_item(ACT_BYTE, id[7:0]);
        repeat (extra)
            send_item(ACT_BYTE, 8'($urandom));
    endtask

    task automatic test_directed();
        send_ack(KIND_CONNACK, 16'h0000, 0);
        send_ack(KIND_CONNACK, 16'hFFFF, 0);
        send_bytes('{8'hD0, 8'h00});
        send_bytes('{8'h00, 8'h01, 8'hAA});
        send_bytes('{8'hF0, 8'h00});
        send_bytes('{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_bytes('{8'h30, 8'h01, 8'h55});
        send_bytes('{8'h90, 8'h02, 8'h00, 8'h01});
        send_item(ACT_SUB, 8'h00);
        send_item(ACT_UNSUB, 8'hFF);
        send_ack(KIND_SUBACK, 16'h0001, 1);
        send_ack(KIND_UNSUBACK, 16'h0002, 0);
        send_ack(KIND_UNSUBACK, 16'h0002, 0);
        send_bytes('{8'h30, 8'h04, 8'h00, 8'h00, 8'h11, 8'h22});
        send_bytes('{8'h30, 8'h04, 8'h00, 8'h03, 8'h11, 8'h22});
        send_publish(1, 2);
        send_item(2'd3, 8'h5A);
        pause_sender();
    endtask

    // A subscribe acknowledge carries at least one return code after the identifier.
    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(($urandom_range(0, 1) != 0) ? ACT_SUB : ACT_UNSUB, 8'($urandom));
        for (int i = 0; i < SLOTS; i++)
            if (pend_valid[i])
                send_ack(pend_kind[i] ? KIND_UNSUBACK : KIND_SUBACK, pend_id[i],
                         pend_kind[i] ? 0 : 1);
        pause_sender();
    endtask

    // The receiver stalls while a long publish floods the block.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_receiver = 1'b0;
            end
            send_publish(3, 60);
        join
        pause_sender();
    endtask

    task automatic test_random(int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned t_len;
        int unsigned p_len;
        int unsigned extra;
        logic [15:0] id;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                t_len = $urandom_range(1, 4);
                p_len = $urandom_range(0, 8);
                send_publish(t_len, p_len);
                sent += 4 + t_len + p_len;
            end
            else if (pick < 50)
            begin
                send_item(($urandom_range(0, 1) != 0) ? ACT_SUB : ACT_UNSUB, 8'($urandom));
                sent += 1;
            end
            else if (pick < 70)
            begin
                id = $urandom_range(0, 3) == 0 ? 16'($urandom) : next_id - 16'($urandom_range(1, 6));
                extra = $urandom_range(0, 2);
                send_ack(($urandom_range(0, 1) != 0) ? KIND_SUBACK : KIND_UNSUBACK, id, extra);
                sent += 4 + extra;
            end
            else if (pick < 80)
            begin
                extra = $urandom_range(0, 1);
                send_ack(KIND_CONNACK, 16'($urandom_range(0, 2)), extra);
                sent += 4 + extra;
            end
            else
            begin
                send_item(2'($urandom), 8'($urandom));
                sent += 1;
            end
        end
    endtask

    // Checks each accepted event against the oldest prediction.
    always @(posedge clk)
    begin
        mqtt_event_t got;
        mqtt_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = make_event(m_tuser, m_tdata[7:0], m_tlast, m_tdata[15:8], m_tdata[31:16]);
            if (expected_events.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event %h", got);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected ev=%0d data=%h end=%b rc=%h id=%h,",
                                  " got ev=%0d data=%h end=%b rc=%h id=%h"},
                                 want.ev, want.data, want.last, want.rc, want.id,
                                 got.ev, got.data, got.last, got.rc, got.id);
                end
            end
        end
    end

    // Receiver idles in bursts of random length.
    always @(posedge clk)
    begin
        if (!rst_n || hold_receiver)
            m_tready <= 1'b0;
        else if (rx_gap != 0)
        begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else if (idle_receiver && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap <= $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        failed = 1'b0;
        idle_sender = 1'b1;
        idle_receiver = 1'b1;
        hold_receiver = 1'b0;
        idle_cycles = 0;
        rx_gap = 0;
        parser_reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(1200);
        idle_sender = 1'b0;
        idle_receiver = 1'b0;
        test_random(450);
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
